>>> rtl/core/hcp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code packer package
// Word types, command codes and fixed constants shared by the packer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcp_pkg;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [7:0] END_MARKER_RESET = 8'd33;

   localparam int BYTE_BITS = 8;
   localparam int ACC_BITS  = 7;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  symbol;
      logic [31:0] code_word;
      logic [5:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       last_of_run;
      logic       stream_end;
   } rsp_type;

endpackage

>>> rtl/core/huffman_code_packer.sv
// ----------------------------------------------------------------------------
// Huffman code packer
// Lookups are registered and queued; output bytes are queued too. Throughput:
// one word a cycle while each yields at most one byte and no queue is full;
// a word yielding k bytes (k <= 5) holds the bit packer until its last byte
// is out. Reset: clears queues, pending bits and length entries, sets end
// marker to '!'; code entries hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_packer #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  hcp_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output hcp_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [7:0]       csr_write_data
);

   localparam int LW       = $clog2(MAX_CODE_LEN + 1);
   localparam int OP_WIDTH = 1 + LW + MAX_CODE_LEN;
   localparam int OP_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   logic                op_push, op_full, op_pop, op_empty;
   logic [OP_WIDTH-1:0] op_push_data, op_pop_data;
   logic                out_push, out_full;
   hcp_pkg::rsp_type    out_data;

   hcp_front #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .SYMBOL_COUNT(SYMBOL_COUNT),
      .OP_WIDTH    (OP_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .req_full      (req_full),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .op_push       (op_push),
      .op_data       (op_push_data),
      .op_full       (op_full)
   );

   hcp_fifo #(
      .WIDTH(OP_WIDTH),
      .DEPTH(OP_DEPTH)
   ) u_op_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (op_push),
      .push_data(op_push_data),
      .full     (op_full),
      .pop      (op_pop),
      .pop_data (op_pop_data),
      .empty    (op_empty)
   );

   hcp_back #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .OP_WIDTH    (OP_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .op_data (op_pop_data),
      .op_empty(op_empty),
      .op_pop  (op_pop),
      .out_push(out_push),
      .out_data(out_data),
      .out_full(out_full)
   );

   hcp_fifo #(
      .WIDTH($bits(hcp_pkg::rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .push_data(out_data),
      .full     (out_full),
      .pop      (rsp_pop),
      .pop_data (rsp_data),
      .empty    (rsp_empty)
   );

endmodule

>>> rtl/core/hcp_fifo.sv
// ----------------------------------------------------------------------------
// Huffman code packer queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

   logic [WIDTH-1:0] store [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign pop_data = store[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/hcp_front.sv
// ----------------------------------------------------------------------------
// Huffman code packer front end
// Accept words, load the code table and look up the code of each encode or
// finish word, then pass it to the bit packer through the operation queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcp_front #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256,
   parameter int OP_WIDTH     = 39
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  hcp_pkg::req_type    req_data,
   output logic                req_full,
   input  logic                csr_write_en,
   input  logic [7:0]          csr_write_data,
   output logic                op_push,
   output logic [OP_WIDTH-1:0] op_data,
   input  logic                op_full
);

   localparam int AW = $clog2(SYMBOL_COUNT);
   localparam int LW = $clog2(MAX_CODE_LEN + 1);
   localparam int EW = LW + MAX_CODE_LEN;

   logic [EW-1:0]           table_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] len_valid_ff;
   logic [EW-1:0]           rd_entry_ff;
   logic                    rd_valid_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_finish_ff;
   logic [7:0]              end_marker_ff;

   logic                    accept, is_load, is_lookup;
   logic [7:0]              sel_symbol;
   logic                    sym_in_range, sel_in_range;
   logic [AW-1:0]           wr_idx, rd_idx;
   logic [LW-1:0]           len_clamped;
   logic [LW-1:0]           rd_len;
   logic [MAX_CODE_LEN-1:0] rd_code;

   assign req_full  = s1_valid_ff && op_full;
   assign op_push   = s1_valid_ff && !op_full;
   assign accept    = req_push && !req_full;
   assign is_load   = accept && (req_data.command == hcp_pkg::CMD_LOAD);
   assign is_lookup = accept && ((req_data.command == hcp_pkg::CMD_ENCODE) ||
                                 (req_data.command == hcp_pkg::CMD_FINISH));

   assign sel_symbol   = (req_data.command == hcp_pkg::CMD_FINISH) ?
                         end_marker_ff : req_data.symbol;
   assign sym_in_range = ({1'b0, req_data.symbol} < 9'(SYMBOL_COUNT));
   assign sel_in_range = ({1'b0, sel_symbol} < 9'(SYMBOL_COUNT));
   assign wr_idx       = req_data.symbol[AW-1:0];
   assign rd_idx       = sel_symbol[AW-1:0];

   assign len_clamped = (req_data.code_length > 6'(MAX_CODE_LEN)) ?
                        LW'(MAX_CODE_LEN) : req_data.code_length[LW-1:0];

   assign rd_len  = rd_valid_ff ? rd_entry_ff[EW-1 -: LW] : '0;
   assign rd_code = rd_valid_ff ? rd_entry_ff[MAX_CODE_LEN-1:0] : '0;
   assign op_data = {s1_finish_ff, rd_len, rd_code};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (op_push) begin
         s1_valid_in = 1'b0;
      end
      if (is_lookup) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         len_valid_ff  <= '0;
         end_marker_ff <= hcp_pkg::END_MARKER_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (is_load && sym_in_range) begin
            len_valid_ff[wr_idx] <= 1'b1;
         end
         if (csr_write_en) begin
            end_marker_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_load && sym_in_range) begin
         table_mem[wr_idx] <= {len_clamped, req_data.code_word[MAX_CODE_LEN-1:0]};
      end
      if (is_lookup) begin
         rd_entry_ff  <= table_mem[rd_idx];
         rd_valid_ff  <= len_valid_ff[rd_idx] && sel_in_range;
         s1_finish_ff <= (req_data.command == hcp_pkg::CMD_FINISH);
      end
   end

endmodule

>>> rtl/core/hcp_back.sv
// ----------------------------------------------------------------------------
// Huffman code packer back end
// Merge each code with the pending bits, emit one byte a cycle while the
// result queue has room, pad and close the stream on finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcp_back #(
   parameter int MAX_CODE_LEN = 32,
   parameter int OP_WIDTH     = 39
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_WIDTH-1:0] op_data,
   input  logic                op_empty,
   output logic                op_pop,
   output logic                out_push,
   output hcp_pkg::rsp_type    out_data,
   input  logic                out_full
);

   localparam int LW = $clog2(MAX_CODE_LEN + 1);
   localparam int AB = hcp_pkg::ACC_BITS;
   localparam int BB = hcp_pkg::BYTE_BITS;
   localparam int WB = MAX_CODE_LEN + AB;
   localparam int TW = $clog2(MAX_CODE_LEN + BB);

   logic [AB-1:0] acc_ff, acc_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [WB-1:0] work_w_ff, work_w_in;
   logic [TW-1:0] work_total_ff, work_total_in;
   logic          work_finish_ff, work_finish_in;

   logic                    head_finish;
   logic [LW-1:0]           head_len;
   logic [MAX_CODE_LEN-1:0] head_code, code_left;
   logic [WB-1:0]           aligned_code, built_w;
   logic [WB-1:0]           cur_w, next_w;
   logic [TW-1:0]           cur_total, next_total;
   logic                    cur_finish, cur_valid;
   logic                    has_full, emit, done, step;

   assign head_finish  = op_data[OP_WIDTH-1];
   assign head_len     = op_data[OP_WIDTH-2 -: LW];
   assign head_code    = op_data[MAX_CODE_LEN-1:0];
   assign code_left    = head_code << (LW'(MAX_CODE_LEN) - head_len);
   assign aligned_code = {code_left, {AB{1'b0}}};
   assign built_w      = {acc_ff, {MAX_CODE_LEN{1'b0}}} | (aligned_code >> cnt_ff);

   assign cur_valid  = busy_ff || !op_empty;
   assign cur_w      = busy_ff ? work_w_ff : built_w;
   assign cur_total  = busy_ff ? work_total_ff : (TW'(cnt_ff) + TW'(head_len));
   assign cur_finish = busy_ff ? work_finish_ff : head_finish;

   assign has_full   = (cur_total >= TW'(BB));
   assign next_w     = cur_w << BB;
   assign next_total = cur_total - TW'(BB);

   always_comb begin
      if (has_full) begin
         emit = 1'b1;
         done = (next_total < TW'(BB)) && !(cur_finish && (next_total != '0));
      end else begin
         emit = cur_finish && (cur_total != '0);
         done = 1'b1;
      end
   end

   assign step     = cur_valid && (!emit || !out_full);
   assign op_pop   = step && !busy_ff;
   assign out_push = step && emit;

   assign out_data.packed_byte = cur_w[WB-1 -: BB];
   assign out_data.last_of_run = done;
   assign out_data.stream_end  = done && cur_finish;

   always_comb begin
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      busy_in        = busy_ff;
      work_w_in      = next_w;
      work_total_in  = next_total;
      work_finish_in = cur_finish;
      if (step) begin
         if (!done) begin
            busy_in = 1'b1;
         end else begin
            busy_in = 1'b0;
            if (cur_finish) begin
               acc_in = '0;
               cnt_in = '0;
            end else if (has_full) begin
               acc_in = next_w[WB-1 -: AB];
               cnt_in = next_total[2:0];
            end else begin
               acc_in = cur_w[WB-1 -: AB];
               cnt_in = cur_total[2:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && !done) begin
         work_w_ff      <= work_w_in;
         work_total_ff  <= work_total_in;
         work_finish_ff <= work_finish_in;
      end
   end

endmodule

>>> dv/huffman_code_packer_test.sv
// ----------------------------------------------------------------------------
// Huffman code packer testbench
// Pushes load, encode and finish words into the packer and checks every
// packed byte, with its run and stream flags, against a local bit-packing
// model or typed row values. A directed table covers the reset state, empty
// finishes, zero, full and overlong code lengths and five-byte runs; random
// words follow in four handshake phases, each after a new end marker is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_packer_test;

   localparam int RESET_CYCLES    = 9;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int STALL_LIMIT     = 4000;
   localparam int REPORT_LIMIT    = 10;
   localparam int MAX_CODE_LEN    = 32;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      hcp_pkg::req_type word;
      logic             typed;
      logic [2:0]       count;
      logic [7:0]       value;
   } plan_row_type;

   localparam plan_row_type PLAN [0:24] = '{
      {hcp_pkg::CMD_LOAD,   8'd33,  32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_FINISH, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_LOAD,   8'h41,  32'h0000_00FF, 6'd8,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'h41,  32'h0000_0000, 6'd0,  1'b1, 3'd1, 8'hFF},
      {hcp_pkg::CMD_LOAD,   8'd0,   32'h0000_0000, 6'd32, 1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'd0,   32'hFFFF_FFFF, 6'd63, 1'b1, 3'd4, 8'h00},
      {hcp_pkg::CMD_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 8'hFF},
      {hcp_pkg::CMD_LOAD,   8'd1,   32'hFFFF_FFFF, 6'd1,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_LOAD,   8'd33,  32'h0000_0005, 6'd3,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_FINISH, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd1, 8'hD0},
      {hcp_pkg::CMD_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd0,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00},
      {CMD_UNUSED,          8'hAA,  32'hFFFF_FFFF, 6'h3F, 1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_LOAD,   8'd3,   32'h1234_5678, 6'd33, 1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_LOAD,   8'd4,   32'h0000_007F, 6'd7,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'd4,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 8'hFF},
      {hcp_pkg::CMD_ENCODE, 8'd3,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00},
      {hcp_pkg::CMD_LOAD,   8'd33,  32'hA5A5_A5A5, 6'd32, 1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_FINISH, 8'd0,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00},
      {hcp_pkg::CMD_ENCODE, 8'h41,  32'h0000_0000, 6'd0,  1'b1, 3'd1, 8'hFF},
      {hcp_pkg::CMD_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00},
      {hcp_pkg::CMD_FINISH, 8'd0,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00}
   };

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_push       = 1'b0;
   hcp_pkg::req_type req_data       = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop        = 1'b0;
   hcp_pkg::rsp_type rsp_data;
   logic             csr_write_en   = 1'b0;
   logic [7:0]       csr_write_data = 8'h00;

   idle_mode_type idle_mode = IDLE_NONE;

   logic [31:0] code_mem [0:255];
   logic [5:0]  len_mem  [0:255];
   logic [6:0]  pending_bits  = '0;
   logic [2:0]  pending_count = '0;
   logic [7:0]  end_marker    = hcp_pkg::END_MARKER_RESET;

   hcp_pkg::rsp_type expected_bytes [$];
   logic [7:0]       loaded_symbols [$];
   logic             loaded_map [0:255];

   int fault_count = 0;
   int stall_cycles = 0;

   huffman_code_packer dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data       (req_data),
      .req_full       (req_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int s = 0; s < 256; s++) begin
         len_mem[s]    = '0;
         loaded_map[s] = 1'b0;
      end
   end

   task automatic report_fault(input string what, input hcp_pkg::rsp_type want,
                               input hcp_pkg::rsp_type got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%s: expected byte %02h last %0b end %0b, got byte %02h last %0b end %0b",
                  what, want.packed_byte, want.last_of_run, want.stream_end,
                  got.packed_byte, got.last_of_run, got.stream_end);
   endtask

   task automatic predict_bytes(input hcp_pkg::req_type w, input logic typed,
                                input logic [2:0] typed_count, input logic [7:0] typed_value);
      hcp_pkg::rsp_type run [0:4];
      hcp_pkg::rsp_type word_out;
      logic [7:0]       sym;
      logic [7:0]       shifted;
      int               n;
      n = 0;
      if (w.command == hcp_pkg::CMD_LOAD) begin
         code_mem[w.symbol] = w.code_word;
         len_mem[w.symbol]  = (w.code_length > MAX_CODE_LEN) ? 6'(MAX_CODE_LEN) : w.code_length;
      end else if (w.command == hcp_pkg::CMD_ENCODE || w.command == hcp_pkg::CMD_FINISH) begin
         sym = (w.command == hcp_pkg::CMD_ENCODE) ? w.symbol : end_marker;
         for (int j = len_mem[sym]; j > 0; j--) begin
            shifted = {pending_bits, code_mem[sym][j - 1]};
            if (pending_count == 3'd7) begin
               run[n] = {shifted, 2'b00};
               n++;
               pending_bits  = '0;
               pending_count = '0;
            end else begin
               pending_bits  = shifted[6:0];
               pending_count = pending_count + 3'd1;
            end
         end
         if (w.command == hcp_pkg::CMD_FINISH) begin
            if (pending_count != 3'd0) begin
               shifted = {1'b0, pending_bits} << (hcp_pkg::BYTE_BITS - pending_count);
               run[n]  = {shifted, 2'b00};
               n++;
            end
            pending_bits  = '0;
            pending_count = '0;
         end
      end
      if (typed) begin
         n = typed_count;
         for (int k = 0; k < n; k++)
            run[k] = {typed_value, 2'b00};
      end
      for (int k = 0; k < n; k++) begin
         word_out             = run[k];
         word_out.last_of_run = (k == n - 1);
         word_out.stream_end  = (k == n - 1) && (w.command == hcp_pkg::CMD_FINISH);
         expected_bytes.push_back(word_out);
      end
   endtask

   task automatic note_load(input hcp_pkg::req_type w);
      if (w.command == hcp_pkg::CMD_LOAD && !loaded_map[w.symbol]) begin
         loaded_map[w.symbol] = 1'b1;
         loaded_symbols.push_back(w.symbol);
      end
   endtask

   task automatic send_word(input hcp_pkg::req_type w, input logic typed,
                            input logic [2:0] typed_count, input logic [7:0] typed_value);
      while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 67) ||
             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 24)) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      note_load(w);
      predict_bytes(w, typed, typed_count, typed_value);
   endtask

   task automatic settle_and_write_marker(input logic [7:0] marker_value);
      req_push <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= marker_value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      end_marker    = marker_value;
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 67) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 24));
   end

   always @(posedge clock) begin
      hcp_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_bytes.size() == 0) begin
            report_fault("unexpected byte", '0, rsp_data);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.packed_byte !== want.packed_byte ||
                rsp_data.last_of_run !== want.last_of_run ||
                rsp_data.stream_end !== want.stream_end)
               report_fault("byte mismatch", want, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      hcp_pkg::req_type w;
      int               counted;
      int               roll;
      int               len_roll;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(PLAN); i++)
         send_word(PLAN[i].word, PLAN[i].typed, PLAN[i].count, PLAN[i].value);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: settle_and_write_marker(8'd255);
            1: settle_and_write_marker(8'd0);
            2: settle_and_write_marker(
                  loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)]);
            default: settle_and_write_marker(hcp_pkg::END_MARKER_RESET);
         endcase
         idle_mode = idle_mode_type'(phase);
         counted   = 0;
         while (counted < ITEMS_PER_PHASE) begin
            roll          = $urandom_range(0, 99);
            w.symbol      = 8'($urandom_range(0, 255));
            w.code_word   = $urandom;
            w.code_length = 6'($urandom_range(0, 63));
            if (roll < 20) begin
               w.command = hcp_pkg::CMD_LOAD;
               len_roll  = $urandom_range(0, 99);
               if (len_roll < 8)
                  w.code_length = 6'd0;
               else if (len_roll < 70)
                  w.code_length = 6'($urandom_range(1, 10));
               else if (len_roll < 93)
                  w.code_length = 6'($urandom_range(11, MAX_CODE_LEN));
               else
                  w.code_length = 6'($urandom_range(MAX_CODE_LEN + 1, 63));
            end else if (roll < 85) begin
               w.command = hcp_pkg::CMD_ENCODE;
               w.symbol  = loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)];
            end else if (roll < 97) begin
               w.command = hcp_pkg::CMD_FINISH;
            end else begin
               w.command = CMD_UNUSED;
            end
            if (w.command != CMD_UNUSED)
               counted++;
            send_word(w, 1'b0, 3'd0, 8'h00);
         end
      end

      req_push <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/hcp_pkg.sv
rtl/core/hcp_fifo.sv
rtl/core/hcp_front.sv
rtl/core/hcp_back.sv
rtl/core/huffman_code_packer.sv
dv/huffman_code_packer_test.sv
